>>> sv/pgfb_pkg.sv
package pgfb_pkg;

  // Operation codes carried in the func field of a request.
  typedef enum logic [2:0] {
    FN_PIXEL       = 3'd0,
    FN_RECT        = 3'd1,
    FN_CURSOR      = 3'd2,
    FN_GLYPH_START = 3'd3,
    FN_GLYPH_ROW   = 3'd4,
    FN_GLYPH_END   = 3'd5,
    FN_READ        = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_RD_ISSUE,
    S_RD_DATA
  } state_e;

  // Fixed field widths.
  localparam int unsigned READ_IDX_W = 10;
  localparam int unsigned PAGE_W     = 5;

  // Glyph and cursor constants.
  localparam int unsigned GLYPH_MAX_W       = 16;
  localparam int unsigned CURSOR_GAP        = 2;
  localparam int unsigned GLYPH_WRAP_MARGIN = 8;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] cursor_column;
    logic [7:0] cursor_row;
  } rsp_t;

endpackage

>>> sv/pgfb_if.sv
interface pgfb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  x;
  logic [7:0]  y;
  logic [7:0]  x_end;
  logic [7:0]  y_end;
  logic        pixel_value;
  logic [4:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [15:0] row_bits;
  logic [5:0]  row_index;
  logic        opaque;
  logic [9:0]  read_index;

  modport source (
    output valid, func, x, y, x_end, y_end, pixel_value, glyph_width,
           glyph_height, row_bits, row_index, opaque, read_index,
    input  ready
  );
  modport sink (
    input  valid, func, x, y, x_end, y_end, pixel_value, glyph_width,
           glyph_height, row_bits, row_index, opaque, read_index,
    output ready
  );
endinterface

interface pgfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] cursor_column;
  logic [7:0] cursor_row;

  modport source (output valid, read_data, cursor_column, cursor_row, input ready);
  modport sink (input valid, read_data, cursor_column, cursor_row, output ready);
endinterface

>>> sv/pgfb_store.sv
module pgfb_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/pgfb_ctrl.sv
module pgfb_ctrl
  import pgfb_pkg::*;
#(
  parameter int unsigned FRAME_WIDTH  = 128,
  parameter int unsigned FRAME_HEIGHT = 64,
  parameter int unsigned STORE_DEPTH  = 1024,
  parameter int unsigned AW           = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pgfb_req_if.sink      req_i,
  input  logic          out_free_i,
  output logic          res_valid_o,
  output rsp_t          res_o,
  output logic          mem_rd_en_o,
  output logic [AW-1:0] mem_rd_addr_o,
  input  logic [7:0]    mem_rd_data_i,
  output logic          mem_wr_en_o,
  output logic [AW-1:0] mem_wr_addr_o,
  output logic [7:0]    mem_wr_data_o
);

  localparam int unsigned IW = ((AW > READ_IDX_W) ? AW : READ_IDX_W) + 1;
  localparam logic [8:0]  WIDTH_LIM  = 9'(FRAME_WIDTH);
  localparam logic [8:0]  HEIGHT_LIM = 9'(FRAME_HEIGHT);
  localparam logic [8:0]  WRAP_COL   = 9'(FRAME_WIDTH - GLYPH_WRAP_MARGIN);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

  state_e state_q, state_d;

  logic [AW-1:0] clr_q, clr_d;
  logic [7:0]    cursor_x_q, cursor_x_d;
  logic [7:0]    cursor_y_q, cursor_y_d;
  logic [4:0]    cur_w_q, cur_w_d;

  // Walk state of the running draw operation.
  logic [7:0]        col_q, col_d;
  logic [7:0]        col_first_q, col_first_d;
  logic [7:0]        col_last_q, col_last_d;
  logic [PAGE_W-1:0] pg_q, pg_d;
  logic [PAGE_W-1:0] pg_last_q, pg_last_d;
  logic [7:0]        ylo_q, ylo_d;
  logic [8:0]        yhi_q, yhi_d;
  logic              glyph_q, glyph_d;
  logic              colour_q, colour_d;
  logic              opaque_q, opaque_d;
  logic [15:0]       bits_q, bits_d;

  // Pending write half of a read-modify-write.
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic [7:0]    wr_mask_q, wr_mask_d;
  logic          wr_val_q, wr_val_d;

  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_ok_q, rd_ok_d;

  logic          accept;
  func_e         func;
  logic [8:0]    x9, xhi_raw, xhi, ylo9, yhi_raw, yhi, yhi_m1;
  logic [7:0]    glyph_row;
  logic          nonempty;
  logic [IW-1:0] ridx_w;

  logic [7:0]    step_mask;
  logic          step_en, step_val, last_col, last_step;
  logic [AW-1:0] step_addr;

  assign accept = req_i.valid && req_i.ready;
  assign func   = func_e'(req_i.func);

  // Decode the draw extents of an incoming request.
  always_comb begin
    x9        = {1'b0, req_i.x};
    glyph_row = cursor_y_q + 8'(req_i.row_index);
    if (func == FN_RECT) begin
      xhi_raw = {1'b0, req_i.x_end};
      ylo9    = {1'b0, req_i.y};
      yhi_raw = {1'b0, req_i.y_end};
    end else if (func == FN_GLYPH_ROW) begin
      xhi_raw = x9 + 9'd1;
      ylo9    = {1'b0, glyph_row};
      yhi_raw = {1'b0, glyph_row} + 9'd1;
    end else begin
      xhi_raw = x9 + 9'd1;
      ylo9    = {1'b0, req_i.y};
      yhi_raw = {1'b0, req_i.y} + 9'd1;
    end
    xhi    = (xhi_raw < WIDTH_LIM) ? xhi_raw : WIDTH_LIM;
    yhi    = (yhi_raw < HEIGHT_LIM) ? yhi_raw : HEIGHT_LIM;
    yhi_m1 = yhi - 9'd1;
    if (func == FN_GLYPH_ROW) begin
      nonempty = (cur_w_q != '0) && (ylo9 < HEIGHT_LIM);
    end else begin
      nonempty = (x9 < xhi) && (ylo9 < yhi);
    end
    ridx_w = IW'(req_i.read_index);
  end

  // Current byte of the walk: address, row mask and the bit value to write.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      step_mask[b] = ({1'b0, pg_q, 3'(b)} >= {1'b0, ylo_q}) &&
                     ({1'b0, pg_q, 3'(b)} < yhi_q);
    end
    if (glyph_q) begin
      step_en  = ({1'b0, col_q} < WIDTH_LIM) && (bits_q[15] || opaque_q);
      step_val = bits_q[15] ? colour_q : ~colour_q;
    end else begin
      step_en  = 1'b1;
      step_val = colour_q;
    end
    step_addr = AW'(32'(col_q) + 32'(pg_q) * 32'(FRAME_WIDTH));
    last_col  = (col_q == col_last_q);
    last_step = last_col && (pg_q == pg_last_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (func)
            FN_PIXEL, FN_RECT, FN_GLYPH_ROW: state_d = nonempty ? S_RUN : S_IDLE;
            FN_READ:                         state_d = S_RD_ISSUE;
            default:                         state_d = S_IDLE;
          endcase
        end
      end
      S_RUN: begin
        if (last_step) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:    state_d = S_IDLE;
      S_RD_ISSUE: begin
        if (out_free_i) begin
          state_d = S_RD_DATA;
        end
      end
      S_RD_DATA:  state_d = S_IDLE;
      default:    state_d = S_CLEAR;
    endcase
  end

  // Outputs: handshake, memory ports and the result.
  always_comb begin
    req_i.ready   = (state_q == S_IDLE);
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = step_addr;
    mem_wr_en_o   = wr_pend_q;
    mem_wr_addr_o = wr_addr_q;
    mem_wr_data_o = (mem_rd_data_i & ~wr_mask_q) | (wr_val_q ? wr_mask_q : 8'h00);
    res_valid_o   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = clr_q;
        mem_wr_data_o = 8'h00;
      end
      S_RUN: begin
        mem_rd_en_o = step_en;
      end
      S_RD_ISSUE: begin
        mem_rd_en_o   = out_free_i;
        mem_rd_addr_o = rd_idx_q;
      end
      S_RD_DATA: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
    res_o.read_data     = rd_ok_q ? mem_rd_data_i : 8'h00;
    res_o.cursor_column = cursor_x_q;
    res_o.cursor_row    = cursor_y_q;
  end

  // Datapath next values.
  always_comb begin
    clr_d       = clr_q;
    cursor_x_d  = cursor_x_q;
    cursor_y_d  = cursor_y_q;
    cur_w_d     = cur_w_q;
    col_d       = col_q;
    col_first_d = col_first_q;
    col_last_d  = col_last_q;
    pg_d        = pg_q;
    pg_last_d   = pg_last_q;
    ylo_d       = ylo_q;
    yhi_d       = yhi_q;
    glyph_d     = glyph_q;
    colour_d    = colour_q;
    opaque_d    = opaque_q;
    bits_d      = bits_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = step_addr;
    wr_mask_d   = step_mask;
    wr_val_d    = step_val;
    rd_idx_d    = rd_idx_q;
    rd_ok_d     = rd_ok_q;

    if (state_q == S_CLEAR) begin
      clr_d = clr_q + AW'(1);
    end

    if (state_q == S_RUN) begin
      wr_pend_d = step_en;
      bits_d    = {bits_q[14:0], 1'b0};
      if (last_col) begin
        col_d = col_first_q;
        pg_d  = pg_q + PAGE_W'(1);
      end else begin
        col_d = col_q + 8'd1;
      end
    end

    if (accept) begin
      glyph_d     = (func == FN_GLYPH_ROW);
      colour_d    = req_i.pixel_value;
      opaque_d    = req_i.opaque;
      bits_d      = req_i.row_bits;
      ylo_d       = ylo9[7:0];
      yhi_d       = yhi;
      pg_d        = ylo9[7:3];
      pg_last_d   = (func == FN_GLYPH_ROW) ? ylo9[7:3] : yhi_m1[7:3];
      rd_idx_d    = ridx_w[AW-1:0];
      rd_ok_d     = ridx_w < IW'(STORE_DEPTH);
      if (func == FN_GLYPH_ROW) begin
        col_d       = cursor_x_q;
        col_first_d = cursor_x_q;
        col_last_d  = cursor_x_q + 8'(cur_w_q) - 8'd1;
      end else begin
        col_d       = req_i.x;
        col_first_d = req_i.x;
        col_last_d  = xhi[7:0] - 8'd1;
      end
      case (func)
        FN_CURSOR: begin
          cursor_x_d = req_i.x;
          cursor_y_d = req_i.y;
        end
        FN_GLYPH_START: begin
          cur_w_d = (req_i.glyph_width > 5'(GLYPH_MAX_W)) ? 5'(GLYPH_MAX_W)
                                                          : req_i.glyph_width;
          if ({1'b0, cursor_x_q} >= WRAP_COL) begin
            cursor_x_d = 8'h00;
            cursor_y_d = cursor_y_q + 8'(req_i.glyph_height) + 8'(CURSOR_GAP);
          end
        end
        FN_GLYPH_END: begin
          cursor_x_d = cursor_x_q + 8'(cur_w_q) + 8'(CURSOR_GAP);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      cur_w_q    <= '0;
      wr_pend_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      cur_w_q    <= cur_w_d;
      wr_pend_q  <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q       <= col_d;
    col_first_q <= col_first_d;
    col_last_q  <= col_last_d;
    pg_q        <= pg_d;
    pg_last_q   <= pg_last_d;
    ylo_q       <= ylo_d;
    yhi_q       <= yhi_d;
    glyph_q     <= glyph_d;
    colour_q    <= colour_d;
    opaque_q    <= opaque_d;
    bits_q      <= bits_d;
    wr_addr_q   <= wr_addr_d;
    wr_mask_q   <= wr_mask_d;
    wr_val_q    <= wr_val_d;
    rd_idx_q    <= rd_idx_d;
    rd_ok_q     <= rd_ok_d;
  end

endmodule

>>> sv/page_framebuffer_glyph_plotter.sv
// Page-ordered 1-bit-per-pixel frame store with pixel, rectangle and glyph drawing.
// Requests arrive on req_i (valid/ready); func selects pixel, rectangle, set cursor,
// glyph start, glyph row, glyph end or read byte. Only a read byte request produces
// a response on rsp_o, carrying the store byte and the current cursor position.
// Cursor requests and empty draws finish in the accept cycle. A pixel, rectangle
// or glyph row walks the touched bytes, one byte per cycle, through a read-modify-
// write on the store's single read and write port: the read of one byte overlaps
// the write of the byte before it (a glyph row walks at most 16 bytes, a rectangle
// one byte per column per page). A read byte request passes the issue state,
// which waits for a free response register, then the data state, in which its
// byte is loaded into that register.
// After reset deasserts, req_i.ready stays low while a clearing pass writes zero
// to every one of the STORE_DEPTH bytes (1024 at the default size); the cursor and
// glyph width reset to zero at once.
// The response register decouples the two sides: drawing requests are still taken
// while a response waits, and only a further read byte request waits for the
// receiver to take the pending response.
module page_framebuffer_glyph_plotter
  import pgfb_pkg::*;
#(
  parameter int unsigned FRAME_WIDTH  = 128,
  parameter int unsigned FRAME_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pgfb_req_if.sink    req_i,
  pgfb_rsp_if.source  rsp_o
);

  // Each page holds eight rows; a partial last page still takes a full row of bytes.
  localparam int unsigned PAGE_COUNT  = (FRAME_HEIGHT + 7) / 8;
  localparam int unsigned STORE_DEPTH = FRAME_WIDTH * PAGE_COUNT;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);

  logic          mem_rd_en, mem_wr_en;
  logic [AW-1:0] mem_rd_addr, mem_wr_addr;
  logic [7:0]    mem_rd_data, mem_wr_data;

  logic          res_valid;
  rsp_t          res;
  logic          out_free;

  logic          rsp_valid_q, rsp_valid_d;
  rsp_t          rsp_q, rsp_d;

  // The controller may issue a store read for a response only when the response
  // register will be free to take it in the following cycle.
  assign out_free = !rsp_valid_q || rsp_o.ready;

  pgfb_ctrl #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .STORE_DEPTH  (STORE_DEPTH),
    .AW           (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data)
  );

  pgfb_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  // Response register: loaded by the controller, emptied when the receiver takes it.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (res_valid) begin
      rsp_valid_d = 1'b1;
      rsp_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.read_data     = rsp_q.read_data;
  assign rsp_o.cursor_column = rsp_q.cursor_column;
  assign rsp_o.cursor_row    = rsp_q.cursor_row;

endmodule

>>> sv/pgfb_checker.sv
module pgfb_checker
  import pgfb_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic [2:0] req_func_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] rsp_read_data_i,
  input logic [7:0] rsp_cursor_column_i,
  input logic [7:0] rsp_cursor_row_i
);

  // A waiting response holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_read_data_i) &&
      $stable(rsp_cursor_column_i) && $stable(rsp_cursor_row_i))
    else $error("response dropped or changed while stalled");

  // The store is being cleared right after reset, so no request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !req_ready_i)
    else $error("request taken during the clearing pass");

  // A read request occupies the block for the next cycle at least.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_func_i == FN_READ) |=> !req_ready_i)
    else $error("request taken while a read was in flight");

  // A new response appears only directly after the block was busy, with ready low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_ready_i))
    else $error("response appeared without a read in progress");

endmodule

bind page_framebuffer_glyph_plotter pgfb_checker u_pgfb_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .req_func_i          (req_i.func),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_read_data_i     (rsp_o.read_data),
  .rsp_cursor_column_i (rsp_o.cursor_column),
  .rsp_cursor_row_i    (rsp_o.cursor_row)
);
